// File: rtl/core/wca_pkg.sv
// ----------------------------------------------------------------------------
// wca_pkg: shared constants and types for the windowed co-occurrence block
// Sizes, register indexes and the history row layout.
// ----------------------------------------------------------------------------
package wca_pkg;

  localparam int NumCodes     = 8;
  localparam int HistDepth    = 256;
  localparam int NumModes     = 3;
  localparam int NumPairs     = NumCodes * NumCodes;
  localparam int HistAw       = $clog2(HistDepth);
  localparam int PairAw       = $clog2(NumPairs);
  localparam int CodeAw       = $clog2(NumCodes);
  localparam int GsumW        = 8 + HistAw + 1;
  localparam int ValW         = GsumW + 3;
  localparam int RowW         = 18;
  localparam int TotW         = 40;
  localparam int CfgAw        = 3;

  localparam logic [RowW-1:0] RowMax = '1;
  localparam logic [TotW-1:0] TotMax = '1;

  localparam logic [CfgAw-1:0] RegOrdered = 3'd0;
  localparam logic [CfgAw-1:0] RegWin0    = 3'd1;
  localparam logic [CfgAw-1:0] RegWin1    = 3'd2;
  localparam logic [CfgAw-1:0] RegWin2    = 3'd3;
  localparam logic [CfgAw-1:0] RegWgt0    = 3'd4;
  localparam logic [CfgAw-1:0] RegWgt1    = 3'd5;
  localparam logic [CfgAw-1:0] RegWgt2    = 3'd6;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] time_s;
    logic [7:0]  codes;
  } hist_row_t;

  function automatic logic [1:0] clamp_mode(input logic [1:0] m);
    clamp_mode = (m >= 2'(NumModes)) ? 2'(NumModes - 1) : m;
  endfunction

endpackage

// File: rtl/core/wca_hist_ram.sv
// ----------------------------------------------------------------------------
// wca_hist_ram: history ring memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wca_hist_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [wca_pkg::HistAw-1:0] waddr_i,
  input  wca_pkg::hist_row_t        wdata_i,
  input  logic [wca_pkg::HistAw-1:0] raddr_i,
  output wca_pkg::hist_row_t        rdata_o
);
  import wca_pkg::*;

  hist_row_t mem_q [HistDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/wca_tot_ram.sv
// ----------------------------------------------------------------------------
// wca_tot_ram: running unit totals per adjacency entry
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wca_tot_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [wca_pkg::PairAw-1:0] waddr_i,
  input  logic [wca_pkg::TotW-1:0]   wdata_i,
  input  logic [wca_pkg::PairAw-1:0] raddr_i,
  output logic [wca_pkg::TotW-1:0]   rdata_o
);
  import wca_pkg::*;

  logic [TotW-1:0] mem_q [NumPairs];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/windowed_cooccurrence_accumulator.sv
// ----------------------------------------------------------------------------
// windowed_cooccurrence_accumulator: windowed ground sums and adjacency totals
// Sequence: a plain row is accepted and then stored. A response row is
// accepted, then walks the history (one memory read per stored row), then
// emits the 64 entries, each a total read and then an output beat that waits
// for the output side to be ready, and is then stored.
// Totals use valid bits (one per entry) cleared by start_unit; no clearing pass.
// Reset: registers to defaults, history empty, totals zero.
// ----------------------------------------------------------------------------
module windowed_cooccurrence_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] code_bits, [39:8] row_time, [41:40] row_mode, [42] is_response,
  // [43] start_unit
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] pair_index, [23:6] row_count, [63:24] total_count
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [wca_pkg::CfgAw-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import wca_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StWalk, StEmitRd, StEmit, StStore
  } state_e;

  state_e state_q;
  logic              ordered_q;
  logic [31:0]       win_q [NumModes];
  logic [7:0]        wgt_q [NumModes];
  logic [7:0]        bits_q;
  logic [31:0]       now_q;
  logic [1:0]        mode_q;
  logic [HistAw:0]   fill_q;
  logic [HistAw-1:0] head_q;
  logic [HistAw:0]   rd_cnt_q;
  logic              rd_vld_q;
  logic [GsumW-1:0]  gsum_q [NumCodes];
  logic [PairAw-1:0] pair_q;
  logic [NumPairs-1:0] tvalid_q;
  logic              out_vld_q;
  logic [63:0]       out_data_q;
  logic              out_last_q;

  hist_row_t         hist_rd;
  hist_row_t         hist_wr;
  logic              hist_we;
  logic [TotW-1:0]   tot_rd;
  logic              tot_we;
  logic [TotW-1:0]   tot_new;
  logic [PairAw-1:0] tot_raddr;

  // ground test on the row read last cycle
  logic [1:0]  gm;
  logic [32:0] reach;
  logic        is_ground;
  always_comb begin
    gm        = clamp_mode(hist_rd.mode);
    reach     = {1'b0, hist_rd.time_s} + {1'b0, win_q[gm]};
    is_ground = rd_vld_q && (reach > {1'b0, now_q});
  end

  // entry value for pair_q
  logic [CodeAw-1:0] gi, rj;
  logic              ri, rjb;
  logic [ValW-1:0]   val;
  logic [ValW-1:0]   wv;
  logic [TotW:0]     tsum;
  always_comb begin
    gi  = pair_q[CodeAw-1:0];
    rj  = pair_q[PairAw-1:CodeAw];
    ri  = bits_q[gi];
    rjb = bits_q[rj];
    wv  = ValW'(wgt_q[clamp_mode(mode_q)]);
    if (ordered_q) begin
      val = rjb ? ValW'({gsum_q[gi], 1'b0}) : '0;
      if (gi != rj && ri && rjb) val = val + wv;
    end else begin
      val = (rjb ? ValW'({gsum_q[gi], 1'b0}) : '0)
          + (ri ? ValW'({gsum_q[rj], 1'b0}) : '0)
          + ((ri && rjb) ? ValW'({wv, 1'b0}) : '0);
    end
    tsum    = {1'b0, (tvalid_q[pair_q] ? tot_rd : {TotW{1'b0}})} + (TotW+1)'(val);
    tot_new = tsum[TotW] ? TotMax : tsum[TotW-1:0];
  end

  logic emit_go;
  assign emit_go = (state_q == StEmit) && (!out_vld_q || m_axis_tready);
  assign tot_we  = emit_go;
  assign tot_raddr = pair_q;

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign hist_we       = (state_q == StStore);
  assign hist_wr       = '{mode: mode_q, time_s: now_q, codes: bits_q};

  wca_hist_ram u_hist (
    .clk_i, .we_i(hist_we), .waddr_i(head_q), .wdata_i(hist_wr),
    .raddr_i(rd_cnt_q[HistAw-1:0]), .rdata_o(hist_rd)
  );

  wca_tot_ram u_tot (
    .clk_i, .we_i(tot_we), .waddr_i(pair_q), .wdata_i(tot_new),
    .raddr_i(tot_raddr), .rdata_o(tot_rd)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ordered_q <= 1'b1;
      for (int m = 0; m < NumModes; m++) begin
        win_q[m] <= '0;
        wgt_q[m] <= 8'd1;
      end
      for (int k = 0; k < NumCodes; k++) gsum_q[k] <= '0;
      bits_q    <= '0;
      now_q     <= '0;
      mode_q    <= '0;
      fill_q    <= '0;
      head_q    <= '0;
      rd_cnt_q  <= '0;
      rd_vld_q  <= 1'b0;
      tvalid_q  <= '0;
      out_vld_q <= 1'b0;
      out_data_q <= '0;
      out_last_q <= 1'b0;
      pair_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegOrdered: ordered_q <= cfg_data_i[0];
          RegWin0:    win_q[0] <= cfg_data_i;
          RegWin1:    win_q[1] <= cfg_data_i;
          RegWin2:    win_q[2] <= cfg_data_i;
          RegWgt0:    wgt_q[0] <= cfg_data_i[7:0];
          RegWgt1:    wgt_q[1] <= cfg_data_i[7:0];
          RegWgt2:    wgt_q[2] <= cfg_data_i[7:0];
          default:    ;
        endcase
      end
      if (emit_go) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            bits_q <= s_axis_tdata[7:0];
            now_q  <= s_axis_tdata[39:8];
            mode_q <= s_axis_tdata[41:40];
            for (int k = 0; k < NumCodes; k++) gsum_q[k] <= '0;
            rd_cnt_q <= '0;
            pair_q   <= '0;
            if (s_axis_tdata[43]) begin
              fill_q   <= '0;
              head_q   <= '0;
              tvalid_q <= '0;
            end
            state_q <= s_axis_tdata[42] ? StWalk : StStore;
          end
        end
        StWalk: begin
          if (is_ground) begin
            for (int k = 0; k < NumCodes; k++)
              if (hist_rd.codes[k]) gsum_q[k] <= gsum_q[k] + GsumW'(wgt_q[gm]);
          end
          rd_vld_q <= (rd_cnt_q < fill_q);
          if (rd_cnt_q < fill_q) begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end else if (!rd_vld_q) begin
            state_q <= StEmitRd;
          end
        end
        StEmitRd: state_q <= StEmit;  // total read for pair_q lands
        StEmit: begin
          if (emit_go) begin
            out_data_q <= {tot_new, (val > ValW'(RowMax)) ? RowMax : RowW'(val), pair_q};
            out_last_q <= (pair_q == PairAw'(NumPairs - 1));
            tvalid_q[pair_q] <= 1'b1;
            if (pair_q == PairAw'(NumPairs - 1)) state_q <= StStore;
            else begin
              pair_q  <= pair_q + 1'b1;
              state_q <= StEmitRd;
            end
          end
        end
        StStore: begin
          head_q <= head_q + 1'b1;
          if (fill_q < (HistAw+1)'(HistDepth)) fill_q <= fill_q + 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (HistAw+1)'(HistDepth))
    else $error("history fill beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> rd_cnt_q <= fill_q)
    else $error("history walk past fill");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_we |-> state_q == StEmit)
    else $error("total write outside emit");

endmodule
